[sv/cbd_pkg.sv]
// Package for the CPU bus decode block: sizes, address map, codes and word layouts.
`default_nettype none
package cbd_pkg;

  localparam int RAM_BYTES = 2048;
  localparam int RAM_AW    = $clog2(RAM_BYTES);

  localparam logic [15:0] RAM_TOP   = 16'h1FFF;
  localparam logic [15:0] PPU_TOP   = 16'h3FFF;
  localparam logic [15:0] DMA_REG   = 16'h4014;
  localparam logic [15:0] APU_STAT  = 16'h4015;
  localparam logic [15:0] PAD_ONE_A = 16'h4016;
  localparam logic [15:0] PAD_TWO_A = 16'h4017;
  localparam logic [15:0] IO_TOP    = 16'h401F;
  localparam logic [7:0]  PAD_OPEN  = 8'h40;
  localparam logic [7:0]  PAD_FILL  = 8'h80;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    TGT_OPEN    = 3'd0,
    TGT_RAM     = 3'd1,
    TGT_PPU     = 3'd2,
    TGT_APU     = 3'd3,
    TGT_PAD     = 3'd4,
    TGT_CART    = 3'd5,
    TGT_DMA     = 3'd6,
    TGT_IGNORED = 3'd7
  } target_t;

  // Bit positions of the result word.
  localparam int OB_FWD_WRITE = 16;
  localparam int OB_OAM_WRITE = 33;
  localparam int OB_CPU_STEP  = 50;
  localparam int OB_DMA_BUSY  = 51;
  localparam int OUT_W        = 56;
  localparam int IN_W         = 56;

  typedef struct packed {
    target_t     target;
    logic [15:0] fwd_addr;
    logic        fwd_write;
    logic [7:0]  fwd_wdata;
    logic [7:0]  rdata;
    logic        oam_write;
    logic [7:0]  oam_index;
    logic        cpu_step;
    logic        dma_busy;
    logic        rd_ram;
    logic        dma_rd;
  } stage_t;

endpackage
`default_nettype wire

[sv/cpu_bus_decode_with_oam_dma_unit.sv]
// Top level: CPU bus decode, work RAM, controller ports and sprite DMA sequencer.
//
//  Channel  Ports                         Contents (low bit first)
//  in       in_tvalid/in_tready/in_tdata  addr, wdata, pad_one, pad_two, ext_rdata, oam_base
//           in_tuser                      cmd
//  out      out_tvalid/out_tready         fwd_addr, fwd_write, fwd_wdata, rdata, oam_write,
//           out_tdata / out_tuser         oam_index, oam_data, cpu_step, dma_busy / target
//  cfg      cfg_we/cfg_wdata              cart_present
//
// A word is taken per cycle unless stalled; results pass through s1_r, then out_data_r.
// The work RAM port is used at most once per word, at acceptance; read data is registered.
// Reset clears all control state; the work RAM is not cleared.
// A low out_tready holds the output register; the stage behind it fills, then in_tready drops.
`default_nettype none
module cpu_bus_decode_with_oam_dma_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // addr, wdata, pad_one, pad_two, ext_rdata, oam_base
  input  wire logic [cbd_pkg::IN_W-1:0]  in_tdata,
  // cmd
  input  wire logic [1:0]                in_tuser,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // fwd_addr, fwd_write, fwd_wdata, rdata, oam_write, oam_index, oam_data, cpu_step, dma_busy
  output logic [cbd_pkg::OUT_W-1:0]      out_tdata,
  // target
  output logic [2:0]                     out_tuser,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_wdata
);
  import cbd_pkg::*;

  cmd_t        cmd;
  logic [15:0] addr;
  logic [7:0]  wdata, pad_one, pad_two, ext_rdata, oam_base;

  logic        cart_present_r;
  logic        pad_strobe_r, pad_strobe_nxt;
  logic [7:0]  pad_shift_r [2];
  logic [7:0]  pad_shift_nxt [2];
  logic [7:0]  dma_page_r, dma_page_nxt;
  logic [7:0]  dma_count_r, dma_count_nxt;
  logic        dma_on_r, dma_on_nxt;
  logic        dma_align_r, dma_align_nxt;
  logic [7:0]  dma_byte_r;
  logic        cycle_odd_r, cycle_odd_nxt;

  logic [7:0]  ram_mem [RAM_BYTES];
  logic [7:0]  ram_q_r;
  logic        ram_we, ram_re;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;

  stage_t      s1_nxt, s1_r;
  logic        s1_v_r, s1_adv, in_acc;
  logic        out_v_r;
  logic [OUT_W-1:0] out_data_r;
  target_t     out_tgt_r;
  logic [7:0]  rd_res, oam_data;

  logic        do_read, ram_wr_hit;
  logic [15:0] ra;
  logic [7:0]  pad_cur;

  assign cmd       = cmd_t'(in_tuser);
  assign addr      = in_tdata[15:0];
  assign wdata     = in_tdata[23:16];
  assign pad_one   = in_tdata[31:24];
  assign pad_two   = in_tdata[39:32];
  assign ext_rdata = in_tdata[47:40];
  assign oam_base  = in_tdata[55:48];

  assign s1_adv    = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    pad_strobe_nxt   = pad_strobe_r;
    pad_shift_nxt[0] = pad_shift_r[0];
    pad_shift_nxt[1] = pad_shift_r[1];
    dma_page_nxt     = dma_page_r;
    dma_count_nxt    = dma_count_r;
    dma_on_nxt       = dma_on_r;
    dma_align_nxt    = dma_align_r;
    cycle_odd_nxt    = cycle_odd_r;
    s1_nxt           = '0;
    s1_nxt.target    = TGT_IGNORED;
    do_read          = 1'b0;
    ra               = addr;
    ram_wr_hit       = 1'b0;
    pad_cur          = 8'h00;

    case (cmd)
      CMD_READ: begin
        do_read = 1'b1;
      end
      CMD_WRITE: begin
        if (addr <= RAM_TOP) begin
          s1_nxt.target = TGT_RAM;
          ram_wr_hit    = 1'b1;
        end else if (addr <= PPU_TOP) begin
          s1_nxt.target    = TGT_PPU;
          s1_nxt.fwd_addr  = {13'd0, addr[2:0]};
          s1_nxt.fwd_write = 1'b1;
          s1_nxt.fwd_wdata = wdata;
        end else if (addr == DMA_REG) begin
          s1_nxt.target = TGT_DMA;
          dma_page_nxt  = wdata;
          dma_count_nxt = 8'd0;
          dma_on_nxt    = 1'b1;
          dma_align_nxt = 1'b1;
        end else if (addr == PAD_ONE_A) begin
          s1_nxt.target  = TGT_PAD;
          pad_strobe_nxt = wdata[0];
          if (wdata[0]) begin
            pad_shift_nxt[0] = pad_one;
            pad_shift_nxt[1] = pad_two;
          end
        end else if (addr <= PAD_TWO_A) begin
          s1_nxt.target    = TGT_APU;
          s1_nxt.fwd_addr  = addr;
          s1_nxt.fwd_write = 1'b1;
          s1_nxt.fwd_wdata = wdata;
        end else if (addr <= IO_TOP) begin
          s1_nxt.target = TGT_IGNORED;
        end else if (cart_present_r) begin
          s1_nxt.target    = TGT_CART;
          s1_nxt.fwd_addr  = addr;
          s1_nxt.fwd_write = 1'b1;
          s1_nxt.fwd_wdata = wdata;
        end else begin
          s1_nxt.target = TGT_OPEN;
        end
      end
      CMD_TICK: begin
        cycle_odd_nxt = !cycle_odd_r;
        if (dma_on_r) begin
          if (dma_align_r) begin
            if (cycle_odd_r) dma_align_nxt = 1'b0;
          end else if (!cycle_odd_r) begin
            do_read       = 1'b1;
            ra            = {dma_page_r, dma_count_r};
            s1_nxt.dma_rd = 1'b1;
          end else begin
            s1_nxt.oam_write = 1'b1;
            s1_nxt.oam_index = oam_base + dma_count_r;
            dma_count_nxt    = dma_count_r + 8'd1;
            if (dma_count_nxt == 8'd0) dma_on_nxt = 1'b0;
          end
        end else begin
          s1_nxt.cpu_step = 1'b1;
        end
      end
      default: begin
        s1_nxt.target = TGT_IGNORED;
      end
    endcase

    if (do_read) begin
      if (ra <= RAM_TOP) begin
        s1_nxt.target = TGT_RAM;
        s1_nxt.rd_ram = 1'b1;
      end else if (ra <= PPU_TOP) begin
        s1_nxt.target   = TGT_PPU;
        s1_nxt.fwd_addr = {13'd0, ra[2:0]};
        s1_nxt.rdata    = ext_rdata;
      end else if (ra == APU_STAT) begin
        s1_nxt.target   = TGT_APU;
        s1_nxt.fwd_addr = ra;
        s1_nxt.rdata    = ext_rdata;
      end else if (ra == PAD_ONE_A || ra == PAD_TWO_A) begin
        pad_cur = pad_strobe_r ? (ra[0] ? pad_two : pad_one) : pad_shift_r[ra[0]];
        s1_nxt.target = TGT_PAD;
        s1_nxt.rdata  = PAD_OPEN | {7'd0, pad_cur[0]};
        pad_shift_nxt[ra[0]] = PAD_FILL | {1'b0, pad_cur[7:1]};
      end else if (ra <= IO_TOP) begin
        s1_nxt.target = TGT_OPEN;
      end else if (cart_present_r) begin
        s1_nxt.target   = TGT_CART;
        s1_nxt.fwd_addr = ra;
        s1_nxt.rdata    = ext_rdata;
      end else begin
        s1_nxt.target = TGT_OPEN;
      end
    end

    s1_nxt.dma_busy = dma_on_nxt;
  end

  assign ram_we    = in_acc && ram_wr_hit;
  assign ram_re    = in_acc && s1_nxt.rd_ram;
  assign ram_waddr = addr[RAM_AW-1:0];
  assign ram_raddr = ra[RAM_AW-1:0];

  always_ff @(posedge clk) begin
    if (ram_we) ram_mem[ram_waddr] <= wdata;
    if (ram_re) ram_q_r <= ram_mem[ram_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cart_present_r <= 1'b0;
      pad_strobe_r   <= 1'b0;
      pad_shift_r[0] <= 8'h00;
      pad_shift_r[1] <= 8'h00;
      dma_page_r     <= 8'h00;
      dma_count_r    <= 8'h00;
      dma_on_r       <= 1'b0;
      dma_align_r    <= 1'b0;
      cycle_odd_r    <= 1'b0;
    end else begin
      if (cfg_we) cart_present_r <= cfg_wdata;
      if (in_acc) begin
        pad_strobe_r   <= pad_strobe_nxt;
        pad_shift_r[0] <= pad_shift_nxt[0];
        pad_shift_r[1] <= pad_shift_nxt[1];
        dma_page_r     <= dma_page_nxt;
        dma_count_r    <= dma_count_nxt;
        dma_on_r       <= dma_on_nxt;
        dma_align_r    <= dma_align_nxt;
        cycle_odd_r    <= cycle_odd_nxt;
      end
    end
  end

  assign rd_res   = s1_r.rd_ram ? ram_q_r : s1_r.rdata;
  assign oam_data = s1_r.oam_write ? dma_byte_r : 8'h00;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      dma_byte_r <= 8'h00;
    end else begin
      if (in_tready) s1_v_r <= in_tvalid;
      if (s1_adv) out_v_r <= s1_v_r;
      if (s1_v_r && s1_adv && s1_r.dma_rd) dma_byte_r <= rd_res;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_r <= s1_nxt;
    if (s1_v_r && s1_adv) begin
      out_tgt_r  <= s1_r.target;
      out_data_r <= {4'd0, s1_r.dma_busy, s1_r.cpu_step, oam_data, s1_r.oam_index,
                     s1_r.oam_write, rd_res, s1_r.fwd_wdata, s1_r.fwd_write,
                     s1_r.fwd_addr};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_tgt_r;

endmodule
`default_nettype wire

[sv/cbd_check.sv]
// Port-level checker for the CPU bus decode block, bound to the top level.
`default_nettype none
module cbd_check (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_tvalid,
  input wire logic                      out_tready,
  input wire logic [cbd_pkg::OUT_W-1:0] out_tdata,
  input wire logic [2:0]                out_tuser
);
  import cbd_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Output word valid right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Stalled output word changed.");

  a_step_vs_oam: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[OB_CPU_STEP] && out_tdata[OB_OAM_WRITE]))
    else $error("CPU step and sprite write in the same word.");

  a_oam_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OB_OAM_WRITE] |->
      out_tuser == TGT_IGNORED && !out_tdata[OB_FWD_WRITE])
    else $error("Sprite write word carries a bus access.");

  a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OB_CPU_STEP] |-> !out_tdata[OB_DMA_BUSY])
    else $error("CPU step reported while DMA is busy.");

endmodule

bind cpu_bus_decode_with_oam_dma_unit cbd_check u_cbd_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

[verif/tb_cpu_bus_decode_with_oam_dma_unit.sv]
// Self-checking testbench for the CPU bus decode block with its predictor, stimulus and checks.
`timescale 1ns / 100ps
module tb_cpu_bus_decode_with_oam_dma_unit;
  import cbd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_LIMIT    = 30;
  localparam int DMA_RAM_BYTES  = 8;
  localparam logic [7:0] DMA_RAM_PAGE = 8'h05;

  typedef struct {
    cmd_t        cmd;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  pad_one;
    logic [7:0]  pad_two;
    logic [7:0]  ext_rdata;
    logic [7:0]  oam_base;
  } bus_word_t;

  typedef struct packed {
    target_t     target;
    logic [15:0] fwd_addr;
    logic        fwd_write;
    logic [7:0]  fwd_wdata;
    logic [7:0]  rdata;
    logic        oam_write;
    logic [7:0]  oam_index;
    logic [7:0]  oam_data;
    logic        cpu_step;
    logic        dma_busy;
  } bus_result_t;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  // addr, wdata, pad_one, pad_two, ext_rdata, oam_base
  logic [IN_W-1:0]   in_tdata   = '0;
  // cmd
  logic [1:0]        in_tuser   = CMD_NOP;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // fwd_addr, fwd_write, fwd_wdata, rdata, oam_write, oam_index, oam_data, cpu_step, dma_busy
  logic [OUT_W-1:0]  out_tdata;
  // target
  logic [2:0]        out_tuser;
  logic              cfg_we     = 1'b0;
  logic              cfg_wdata  = 1'b0;

  cpu_bus_decode_with_oam_dma_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // Predicted block state.
  logic [7:0]  ram_image [RAM_BYTES];
  bit          ram_known [RAM_BYTES];
  logic        cart_on;
  logic        strobe_q;
  logic [7:0]  pad_shifter [2];
  logic [7:0]  dma_page_q;
  logic [7:0]  dma_count_q;
  logic        dma_active;
  logic        dma_aligning;
  logic [7:0]  dma_latched;
  logic        odd_cycle;

  bus_result_t pending_results [$];
  int unsigned mismatch_count;
  int unsigned result_index;
  int unsigned idle_cycles;
  int unsigned stall_left;
  bit          quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void decode_read(input logic [15:0] a, input bus_word_t w,
                                      inout bus_result_t r);
    int unsigned p;
    if (a <= RAM_TOP) begin
      r.target = TGT_RAM;
      r.rdata  = ram_image[int'(a & RAM_TOP) % RAM_BYTES];
    end else if (a <= PPU_TOP) begin
      r.target   = TGT_PPU;
      r.fwd_addr = {13'd0, a[2:0]};
      r.rdata    = w.ext_rdata;
    end else if (a == APU_STAT) begin
      r.target   = TGT_APU;
      r.fwd_addr = a;
      r.rdata    = w.ext_rdata;
    end else if (a == PAD_ONE_A || a == PAD_TWO_A) begin
      p = a[0];
      if (strobe_q) pad_shifter[p] = p ? w.pad_two : w.pad_one;
      r.target       = TGT_PAD;
      r.rdata        = {7'd0, pad_shifter[p][0]} | PAD_OPEN;
      pad_shifter[p] = (pad_shifter[p] >> 1) | PAD_FILL;
    end else if (a <= IO_TOP) begin
      r.target = TGT_OPEN;
    end else if (cart_on) begin
      r.target   = TGT_CART;
      r.fwd_addr = a;
      r.rdata    = w.ext_rdata;
    end else begin
      r.target = TGT_OPEN;
    end
  endfunction

  function automatic void decode_write(input bus_word_t w, inout bus_result_t r);
    if (w.addr <= RAM_TOP) begin
      r.target = TGT_RAM;
      ram_image[int'(w.addr & RAM_TOP) % RAM_BYTES] = w.wdata;
      ram_known[int'(w.addr & RAM_TOP) % RAM_BYTES] = 1'b1;
    end else if (w.addr <= PPU_TOP) begin
      r.target    = TGT_PPU;
      r.fwd_addr  = {13'd0, w.addr[2:0]};
      r.fwd_write = 1'b1;
      r.fwd_wdata = w.wdata;
    end else if (w.addr == DMA_REG) begin
      r.target     = TGT_DMA;
      dma_page_q   = w.wdata;
      dma_count_q  = '0;
      dma_active   = 1'b1;
      dma_aligning = 1'b1;
    end else if (w.addr == PAD_ONE_A) begin
      r.target = TGT_PAD;
      strobe_q = w.wdata[0];
      if (strobe_q) begin
        pad_shifter[0] = w.pad_one;
        pad_shifter[1] = w.pad_two;
      end
    end else if (w.addr <= PAD_TWO_A) begin
      r.target    = TGT_APU;
      r.fwd_addr  = w.addr;
      r.fwd_write = 1'b1;
      r.fwd_wdata = w.wdata;
    end else if (w.addr <= IO_TOP) begin
      r.target = TGT_IGNORED;
    end else if (cart_on) begin
      r.target    = TGT_CART;
      r.fwd_addr  = w.addr;
      r.fwd_write = 1'b1;
      r.fwd_wdata = w.wdata;
    end else begin
      r.target = TGT_OPEN;
    end
  endfunction

  function automatic void cpu_tick(input bus_word_t w, inout bus_result_t r);
    r.target = TGT_IGNORED;
    if (dma_active) begin
      if (dma_aligning) begin
        if (odd_cycle) dma_aligning = 1'b0;
      end else if (!odd_cycle) begin
        decode_read({dma_page_q, dma_count_q}, w, r);
        dma_latched = r.rdata;
      end else begin
        r.oam_write = 1'b1;
        r.oam_index = w.oam_base + dma_count_q;
        r.oam_data  = dma_latched;
        dma_count_q = dma_count_q + 8'd1;
        if (dma_count_q == 8'd0) dma_active = 1'b0;
      end
    end else begin
      r.cpu_step = 1'b1;
    end
    odd_cycle = ~odd_cycle;
  endfunction

  function automatic bus_result_t bus_outcome(input bus_word_t w);
    bus_result_t r;
    r = '0;
    case (w.cmd)
      CMD_READ:  decode_read(w.addr, w, r);
      CMD_WRITE: decode_write(w, r);
      CMD_TICK:  cpu_tick(w, r);
      default:   r.target = TGT_IGNORED;
    endcase
    r.dma_busy = dma_active;
    return r;
  endfunction

  function automatic int unsigned draw_wait();
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic bus_word_t make_word(input cmd_t c, input logic [15:0] a,
                                          input logic [7:0] d);
    bus_word_t w;
    w.cmd       = c;
    w.addr      = a;
    w.wdata     = d;
    w.pad_one   = 8'($urandom);
    w.pad_two   = 8'($urandom);
    w.ext_rdata = 8'($urandom);
    w.oam_base  = 8'($urandom);
    return w;
  endfunction

  function automatic bus_word_t random_word(input bit allow_dma_start);
    bus_word_t   w;
    int unsigned pick;
    logic [15:0] a;
    case ($urandom_range(0, 5))
      0:       a = 16'($urandom_range(0, RAM_TOP));
      1:       a = 16'($urandom_range(RAM_TOP + 1, PPU_TOP));
      2:       a = 16'($urandom_range(16'h4000, IO_TOP));
      3:       a = 16'($urandom_range(DMA_REG, PAD_TWO_A));
      4:       a = 16'($urandom_range(IO_TOP + 1, 16'hFFFF));
      default: a = 16'($urandom);
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 50)      w = make_word(CMD_TICK, a, 8'($urandom));
    else if (pick < 70) w = make_word(CMD_READ, a, 8'($urandom));
    else if (pick < 96) w = make_word(CMD_WRITE, a, 8'($urandom));
    else                w = make_word(CMD_NOP, a, 8'($urandom));
    if (w.cmd == CMD_READ && w.addr <= RAM_TOP &&
        !ram_known[int'(w.addr & RAM_TOP) % RAM_BYTES])
      w.cmd = CMD_WRITE;
    if (w.cmd == CMD_WRITE && w.addr == DMA_REG) begin
      if (!allow_dma_start) w.cmd = CMD_READ;
      else if (w.wdata[7:5] == 3'd0) w.wdata[5] = 1'b1;
    end
    return w;
  endfunction

  task automatic send_word(input bus_word_t w);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= w.cmd;
    in_tdata  <= {w.oam_base, w.ext_rdata, w.pad_two, w.pad_one, w.wdata, w.addr};
    pending_results.insert(pending_results.size(), bus_outcome(w));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_cart_present(input logic v);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cart_on = v;
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] result %0d: %s is %h, expected %h", $realtime, result_index, what,
               got, want);
    mismatch_count++;
  endtask

  // Reset state: even first tick, cleared shifters, cartridge absent.
  task automatic test_reset_state();
    send_word(make_word(CMD_TICK, 16'h0000, 8'h00));
    send_word(make_word(CMD_TICK, 16'hFFFF, 8'hFF));
    send_word(make_word(CMD_NOP, 16'h4014, 8'h01));
    send_word(make_word(CMD_READ, PAD_ONE_A, 8'h00));
    send_word(make_word(CMD_READ, PAD_TWO_A, 8'h00));
    send_word(make_word(CMD_READ, 16'h4020, 8'h00));
    send_word(make_word(CMD_WRITE, 16'hFFFF, 8'hA5));
    send_word(make_word(CMD_WRITE, 16'h4020, 8'h5A));
    send_word(make_word(CMD_READ, 16'h4000, 8'h00));
  endtask

  task automatic test_decode_map();
    send_word(make_word(CMD_WRITE, 16'h0000, 8'hFF));
    send_word(make_word(CMD_READ, 16'h0000, 8'h00));
    send_word(make_word(CMD_WRITE, RAM_TOP, 8'h00));
    send_word(make_word(CMD_READ, 16'h07FF, 8'hFF));
    send_word(make_word(CMD_READ, 16'h2000, 8'h00));
    send_word(make_word(CMD_WRITE, PPU_TOP, 8'hFF));
    send_word(make_word(CMD_READ, 16'h4000, 8'h00));
    send_word(make_word(CMD_WRITE, 16'h4013, 8'h3C));
    send_word(make_word(CMD_READ, APU_STAT, 8'h00));
    send_word(make_word(CMD_WRITE, APU_STAT, 8'h0F));
    send_word(make_word(CMD_WRITE, PAD_TWO_A, 8'hC0));
    send_word(make_word(CMD_READ, DMA_REG, 8'h00));
    send_word(make_word(CMD_WRITE, 16'h4018, 8'h77));
    send_word(make_word(CMD_READ, IO_TOP, 8'h00));
    send_word(make_word(CMD_READ, 16'h4020, 8'h00));
    send_word(make_word(CMD_WRITE, 16'hFFFF, 8'hFF));
    send_word(make_word(CMD_WRITE, PAD_ONE_A, 8'h01));
    send_word(make_word(CMD_READ, PAD_ONE_A, 8'h00));
    send_word(make_word(CMD_READ, PAD_TWO_A, 8'h00));
    send_word(make_word(CMD_WRITE, PAD_ONE_A, 8'hFE));
    send_word(make_word(CMD_READ, PAD_ONE_A, 8'h00));
    send_word(make_word(CMD_READ, PAD_ONE_A, 8'h00));
    send_word(make_word(CMD_READ, PAD_TWO_A, 8'h00));
    send_word(make_word(CMD_NOP, 16'h0000, 8'h00));
  endtask

  // A transfer of eight written RAM bytes is left running; the next DMA start cuts it short.
  task automatic test_dma_restart();
    for (int i = 0; i < DMA_RAM_BYTES; i++)
      send_word(make_word(CMD_WRITE, 16'(int'({DMA_RAM_PAGE, 8'(i)}) +
                                         RAM_BYTES * int'($urandom_range(0, 3))),
                          8'($urandom)));
    send_word(make_word(CMD_WRITE, DMA_REG, DMA_RAM_PAGE));
    while (dma_count_q != 8'(DMA_RAM_BYTES))
      send_word(make_word(CMD_TICK, 16'($urandom), 8'($urandom)));
  endtask

  // One sprite transfer runs to completion, with occasional bus accesses in between.
  task automatic test_full_dma(input logic [7:0] page);
    send_word(make_word(CMD_WRITE, DMA_REG, page));
    while (dma_active) begin
      if ($urandom_range(0, 23) == 0) send_word(random_word(1'b0));
      else send_word(make_word(CMD_TICK, 16'($urandom), 8'($urandom)));
    end
  endtask

  task automatic test_random_mix(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
      send_word(random_word(1'b1));
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin : drive_ready
    int unsigned out_gap;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (out_tready && out_tvalid) begin
      out_gap = draw_wait();
      if (out_gap == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        stall_left <= out_gap - 1;
      end
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    bus_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, tdata[15:0]", out_tdata[15:0], 16'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser != want.target)
          report_mismatch("target", 16'(out_tuser), 16'(want.target));
        if (out_tdata[15:0] != want.fwd_addr)
          report_mismatch("fwd_addr", out_tdata[15:0], want.fwd_addr);
        if (out_tdata[16] != want.fwd_write)
          report_mismatch("fwd_write", 16'(out_tdata[16]), 16'(want.fwd_write));
        if (out_tdata[24:17] != want.fwd_wdata)
          report_mismatch("fwd_wdata", 16'(out_tdata[24:17]), 16'(want.fwd_wdata));
        if (out_tdata[32:25] != want.rdata)
          report_mismatch("rdata", 16'(out_tdata[32:25]), 16'(want.rdata));
        if (out_tdata[33] != want.oam_write)
          report_mismatch("oam_write", 16'(out_tdata[33]), 16'(want.oam_write));
        if (out_tdata[41:34] != want.oam_index)
          report_mismatch("oam_index", 16'(out_tdata[41:34]), 16'(want.oam_index));
        if (out_tdata[49:42] != want.oam_data)
          report_mismatch("oam_data", 16'(out_tdata[49:42]), 16'(want.oam_data));
        if (out_tdata[50] != want.cpu_step)
          report_mismatch("cpu_step", 16'(out_tdata[50]), 16'(want.cpu_step));
        if (out_tdata[51] != want.dma_busy)
          report_mismatch("dma_busy", 16'(out_tdata[51]), 16'(want.dma_busy));
      end
      result_index++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cart_on        = 1'b0;
    strobe_q       = 1'b0;
    pad_shifter[0] = '0;
    pad_shifter[1] = '0;
    dma_page_q     = '0;
    dma_count_q    = '0;
    dma_active     = 1'b0;
    dma_aligning   = 1'b0;
    dma_latched    = '0;
    odd_cycle      = 1'b0;
    mismatch_count = 0;
    result_index   = 0;
    quiet          = 1'b0;
    for (int i = 0; i < RAM_BYTES; i++) ram_known[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    set_cart_present(1'b1);
    test_decode_map();
    test_dma_restart();
    test_full_dma(8'h40);
    test_random_mix(25);
    set_cart_present(1'b0);
    test_random_mix(25);
    set_cart_present(1'b1);
    test_random_mix(25);

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
